### hdl/tfch_pkg.sv
package tfch_pkg;

  // default geometry
  localparam int FRONT_LEN_DEF = 32;
  localparam int BACK_LEN_DEF  = 40;
  localparam int BURST_MAX_DEF = 128;

  // register reset values
  localparam logic [7:0] FRONT_HEADER_RST = 8'h38;
  localparam logic [7:0] BACK_HEADER_RST  = 8'h39;
  localparam logic [3:0] FAULT_LIMIT_RST  = 4'd5;

  // fail run saturates here
  localparam logic [3:0] FAIL_RUN_MAX = 4'd15;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRONT_HEADER = 2'd0,
    REG_BACK_HEADER  = 2'd1,
    REG_FAULT_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ITEM_FRONT  = 2'd0,
    ITEM_BACK   = 2'd1,
    ITEM_STATUS = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    CODE_DATA_OK   = 2'd0,
    CODE_FRONT_ERR = 2'd1,
    CODE_BACK_ERR  = 2'd2,
    CODE_NO_LINK   = 2'd3
  } fault_code_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_FRONT,
    EM_BACK,
    EM_STATUS
  } emit_state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_burst;
    logic       empty_burst;
  } byte_beat_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [63:0] frame_word;
    logic [2:0]  word_number;
    logic        front_ok;
    logic        back_ok;
    logic        link_error;
    logic        front_fault;
    logic        back_fault;
    logic [1:0]  fault_code;
    logic        last_result;
  } result_beat_t;

  typedef struct packed {
    logic [7:0] front_header;
    logic [7:0] back_header;
    logic [3:0] fault_limit;
  } cfg_regs_t;

  // end-of-burst event from hunter to emitter
  typedef struct packed {
    logic       valid;
    logic       front_cap;
    logic       back_cap;
    logic       front_ok;
    logic       back_ok;
    logic       link_error;
    logic       front_fault;
    logic       back_fault;
    logic [1:0] fault_code;
  } burst_end_t;

endpackage

### hdl/tfch_cell.sv
module tfch_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift_en,
  input  logic [7:0] prev_byte,
  output logic [7:0] held
);

  // one window byte, takes its neighbor's byte on each shift
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift_en) begin
      held <= prev_byte;
    end
  end

endmodule

### hdl/tfch_hunter.sv
module tfch_hunter
  import tfch_pkg::*;
#(
  parameter int FRONT_LEN = FRONT_LEN_DEF,
  parameter int BACK_LEN  = BACK_LEN_DEF,
  parameter int BURST_MAX = BURST_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  byte_beat_t                  beat,
  input  cfg_regs_t                   cfg,
  output burst_end_t                  end_evt,
  output logic [FRONT_LEN-1:0][7:0]   front_frame,
  output logic [BACK_LEN-1:0][7:0]    back_frame
);

  localparam int WIN_DEPTH = (FRONT_LEN > BACK_LEN) ? FRONT_LEN : BACK_LEN;
  localparam int CNT_W     = $clog2(BURST_MAX + 1);
  localparam logic [CNT_W-1:0] BURST_CAP = CNT_W'(BURST_MAX);
  localparam logic [CNT_W-1:0] FRONT_CNT = CNT_W'(FRONT_LEN);
  localparam logic [CNT_W-1:0] BACK_CNT  = CNT_W'(BACK_LEN);

  logic [7:0]       win     [WIN_DEPTH];
  logic [7:0]       win_new [WIN_DEPTH];
  logic [7:0]       front_sum, back_sum;
  logic [7:0]       front_sum_new, back_sum_new;
  logic [CNT_W-1:0] byte_count, count_new;
  logic             front_captured, back_captured;
  logic             front_good, back_good;
  logic [3:0]       front_fail_run, back_fail_run;
  logic [3:0]       front_run_next, back_run_next;
  logic             hunting, front_hit, back_hit;
  logic             front_cap_now, back_cap_now;
  logic             burst_done, burst_empty;
  logic             front_fault_next, back_fault_next;
  burst_end_t       end_next;

  function automatic logic [3:0] step_run(input logic [3:0] run, input logic good);
    logic [3:0] res;
    if (good) begin
      res = '0;
    end else if (run == FAIL_RUN_MAX) begin
      res = run;
    end else begin
      res = run + 4'd1;
    end
    return res;
  endfunction

  // bytes past the burst cap are dropped
  assign hunting     = take && !beat.empty_burst && (byte_count < BURST_CAP);
  assign burst_done  = take && !beat.empty_burst && beat.last_in_burst;
  assign burst_empty = take && beat.empty_burst;

  // window after this byte: cell k takes win_new[k]
  always_comb begin
    win_new[0] = beat.rx_byte;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_new[k] = win[k-1];
    end
  end

  // row of window cells
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    tfch_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (hunting),
      .prev_byte (win_new[k]),
      .held      (win[k])
    );
  end

  // running sums and frame match
  assign front_sum_new = front_sum + beat.rx_byte - win[FRONT_LEN-1];
  assign back_sum_new  = back_sum + beat.rx_byte - win[BACK_LEN-1];
  assign count_new     = byte_count + 1'b1;

  assign front_hit = hunting && !front_captured && (count_new >= FRONT_CNT) &&
                     (win_new[FRONT_LEN-1] == cfg.front_header) && (front_sum_new == '0);
  assign back_hit  = hunting && !back_captured && (count_new >= BACK_CNT) &&
                     (win_new[BACK_LEN-1] == cfg.back_header) && (back_sum_new == '0);

  assign front_cap_now = front_captured || front_hit;
  assign back_cap_now  = back_captured || back_hit;

  // burst verdict
  assign front_run_next   = step_run(front_fail_run, front_cap_now);
  assign back_run_next    = step_run(back_fail_run, back_cap_now);
  assign front_fault_next = front_run_next > cfg.fault_limit;
  assign back_fault_next  = back_run_next > cfg.fault_limit;

  always_comb begin
    end_next = '0;
    if (burst_empty) begin
      end_next.valid       = 1'b1;
      end_next.front_ok    = front_good;
      end_next.back_ok     = back_good;
      end_next.link_error  = 1'b1;
      end_next.front_fault = front_fail_run > cfg.fault_limit;
      end_next.back_fault  = back_fail_run > cfg.fault_limit;
      end_next.fault_code  = CODE_NO_LINK;
    end else if (burst_done) begin
      end_next.valid       = 1'b1;
      end_next.front_cap   = front_cap_now;
      end_next.back_cap    = back_cap_now;
      end_next.front_ok    = front_cap_now;
      end_next.back_ok     = back_cap_now;
      end_next.front_fault = front_fault_next;
      end_next.back_fault  = back_fault_next;
      if (!front_fault_next && !back_fault_next) begin
        end_next.fault_code = CODE_DATA_OK;
      end else if (!back_fault_next) begin
        end_next.fault_code = CODE_FRONT_ERR;
      end else begin
        end_next.fault_code = CODE_BACK_ERR;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      front_sum      <= '0;
      back_sum       <= '0;
      byte_count     <= '0;
      front_captured <= 1'b0;
      back_captured  <= 1'b0;
      front_good     <= 1'b1;
      back_good      <= 1'b1;
      front_fail_run <= '0;
      back_fail_run  <= '0;
      end_evt        <= '0;
    end else begin
      end_evt <= end_next;
      if (hunting) begin
        front_sum  <= front_sum_new;
        back_sum   <= back_sum_new;
        byte_count <= count_new;
      end
      if (front_hit) begin
        front_captured <= 1'b1;
      end
      if (back_hit) begin
        back_captured <= 1'b1;
      end
      if (burst_done) begin
        front_good     <= front_cap_now;
        back_good      <= back_cap_now;
        front_fail_run <= front_run_next;
        back_fail_run  <= back_run_next;
      end
      if (burst_done || burst_empty) begin
        byte_count     <= '0;
        front_captured <= 1'b0;
        back_captured  <= 1'b0;
      end
    end
  end

  // frame stores, oldest byte first
  always_ff @(posedge clk) begin
    if (front_hit) begin
      for (int i = 0; i < FRONT_LEN; i++) begin
        front_frame[i] <= win_new[FRONT_LEN-1-i];
      end
    end
    if (back_hit) begin
      for (int i = 0; i < BACK_LEN; i++) begin
        back_frame[i] <= win_new[BACK_LEN-1-i];
      end
    end
  end

  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    take && (beat.last_in_burst || beat.empty_burst) |=> end_evt.valid)
    else $error("burst end beat produced no end event");

  a_end_single: assert property (@(posedge clk) disable iff (rst)
    end_evt.valid |=> !end_evt.valid)
    else $error("end events back to back, emitter would miss one");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    end_evt.valid && !end_evt.link_error && end_evt.front_ok |-> front_fail_run == '0)
    else $error("front fail run not cleared on a good burst");

endmodule

### hdl/tfch_emitter.sv
module tfch_emitter
  import tfch_pkg::*;
#(
  parameter int FRONT_LEN = FRONT_LEN_DEF,
  parameter int BACK_LEN  = BACK_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  burst_end_t                end_evt,
  input  logic [FRONT_LEN-1:0][7:0] front_frame,
  input  logic [BACK_LEN-1:0][7:0]  back_frame,
  input  logic                      result_stall,
  output logic                      result_valid,
  output result_beat_t              result_beat,
  output logic                      busy
);

  localparam int FRONT_WORDS = (FRONT_LEN + 7) / 8;
  localparam int BACK_WORDS  = (BACK_LEN + 7) / 8;
  localparam int FW_IDX_W    = (FRONT_WORDS > 1) ? $clog2(FRONT_WORDS) : 1;
  localparam int BW_IDX_W    = (BACK_WORDS > 1) ? $clog2(BACK_WORDS) : 1;
  localparam logic [2:0] FRONT_LAST = 3'(FRONT_WORDS - 1);
  localparam logic [2:0] BACK_LAST  = 3'(BACK_WORDS - 1);

  emit_state_t state, state_next;
  logic [2:0]  word_idx;
  logic        advance, load;
  logic        back_cap;
  burst_end_t  status;
  logic [63:0] front_rows [FRONT_WORDS];
  logic [63:0] back_rows  [BACK_WORDS];
  logic [63:0] front_pad  [FRONT_WORDS];
  logic [63:0] back_pad   [BACK_WORDS];

  assign advance = (state != EM_IDLE) && !result_stall;
  assign load    = (state == EM_IDLE) && end_evt.valid;

  // pack stores into 64-bit words, zero past the frame end
  always_comb begin
    for (int w = 0; w < FRONT_WORDS; w++) begin
      front_pad[w] = '0;
      for (int j = 0; j < 8; j++) begin
        if (w * 8 + j < FRONT_LEN) begin
          front_pad[w][8*j +: 8] = front_frame[w*8+j];
        end
      end
    end
    for (int w = 0; w < BACK_WORDS; w++) begin
      back_pad[w] = '0;
      for (int j = 0; j < 8; j++) begin
        if (w * 8 + j < BACK_LEN) begin
          back_pad[w][8*j +: 8] = back_frame[w*8+j];
        end
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      EM_IDLE: begin
        if (end_evt.valid) begin
          if (end_evt.front_cap) begin
            state_next = EM_FRONT;
          end else if (end_evt.back_cap) begin
            state_next = EM_BACK;
          end else begin
            state_next = EM_STATUS;
          end
        end
      end
      EM_FRONT: begin
        if (advance && word_idx == FRONT_LAST) begin
          state_next = back_cap ? EM_BACK : EM_STATUS;
        end
      end
      EM_BACK: begin
        if (advance && word_idx == BACK_LAST) begin
          state_next = EM_STATUS;
        end
      end
      EM_STATUS: begin
        if (advance) begin
          state_next = EM_IDLE;
        end
      end
      default: state_next = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= EM_IDLE;
      word_idx <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        word_idx <= '0;
      end else if (advance) begin
        word_idx <= word_idx + 3'd1;
      end
    end
  end

  // snapshot of the finished burst
  always_ff @(posedge clk) begin
    if (load) begin
      back_cap <= end_evt.back_cap;
      status   <= end_evt;
      for (int w = 0; w < FRONT_WORDS; w++) begin
        front_rows[w] <= front_pad[w];
      end
      for (int w = 0; w < BACK_WORDS; w++) begin
        back_rows[w] <= back_pad[w];
      end
    end
  end

  // result beat
  always_comb begin
    result_beat = '0;
    case (state)
      EM_FRONT: begin
        result_beat.item_kind   = ITEM_FRONT;
        result_beat.frame_word  = front_rows[word_idx[FW_IDX_W-1:0]];
        result_beat.word_number = word_idx;
      end
      EM_BACK: begin
        result_beat.item_kind   = ITEM_BACK;
        result_beat.frame_word  = back_rows[word_idx[BW_IDX_W-1:0]];
        result_beat.word_number = word_idx;
      end
      EM_STATUS: begin
        result_beat.item_kind   = ITEM_STATUS;
        result_beat.front_ok    = status.front_ok;
        result_beat.back_ok     = status.back_ok;
        result_beat.link_error  = status.link_error;
        result_beat.front_fault = status.front_fault;
        result_beat.back_fault  = status.back_fault;
        result_beat.fault_code  = status.fault_code;
        result_beat.last_result = 1'b1;
      end
      default: result_beat = '0;
    endcase
  end

  assign result_valid = (state != EM_IDLE);
  assign busy         = result_valid;

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    end_evt.valid |-> state == EM_IDLE)
    else $error("end event arrived while results still draining");

  a_front_range: assert property (@(posedge clk) disable iff (rst)
    state == EM_FRONT |-> word_idx <= FRONT_LAST)
    else $error("front word index past frame end");

  a_back_to_status: assert property (@(posedge clk) disable iff (rst)
    state == EM_BACK && !result_stall && word_idx == BACK_LAST |=> state == EM_STATUS)
    else $error("status beat did not follow last back word");

endmodule

### hdl/two_frame_checksum_hunter.sv
// Takes one byte per cycle unless stalled; only closing and empty-read bytes can stall.
// Results: closing byte -> end event register -> emitter state; then one beat per
// cycle unless stalled (frame words, then status), up to 10 beats with default lengths.
// A closing or empty-read byte is held off while the previous burst's results drain.
// Reset (rst, synchronous, active high): registers to defaults, window and sums to zero,
// fail runs cleared, good flags set; frame stores keep their contents.
module two_frame_checksum_hunter
  import tfch_pkg::*;
#(
  parameter int FRONT_LEN = FRONT_LEN_DEF,
  parameter int BACK_LEN  = BACK_LEN_DEF,
  parameter int BURST_MAX = BURST_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_beat_t   byte_beat,
  output logic         result_valid,
  input  logic         result_stall,
  output result_beat_t result_beat,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  cfg_regs_t                 cfg;
  burst_end_t                end_evt;
  logic [FRONT_LEN-1:0][7:0] front_frame;
  logic [BACK_LEN-1:0][7:0]  back_frame;
  logic                      emit_busy;
  logic                      take;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_header <= FRONT_HEADER_RST;
      cfg.back_header  <= BACK_HEADER_RST;
      cfg.fault_limit  <= FAULT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRONT_HEADER: cfg.front_header <= cfg_data;
        REG_BACK_HEADER:  cfg.back_header  <= cfg_data;
        REG_FAULT_LIMIT:  cfg.fault_limit  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // a burst-closing beat waits until the emitter is free
  assign byte_stall = (byte_beat.last_in_burst || byte_beat.empty_burst) &&
                      (end_evt.valid || emit_busy);
  assign take       = byte_valid && !byte_stall;

  tfch_hunter #(
    .FRONT_LEN (FRONT_LEN),
    .BACK_LEN  (BACK_LEN),
    .BURST_MAX (BURST_MAX)
  ) u_hunter (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .beat        (byte_beat),
    .cfg         (cfg),
    .end_evt     (end_evt),
    .front_frame (front_frame),
    .back_frame  (back_frame)
  );

  tfch_emitter #(
    .FRONT_LEN (FRONT_LEN),
    .BACK_LEN  (BACK_LEN)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .end_evt      (end_evt),
    .front_frame  (front_frame),
    .back_frame   (back_frame),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_beat  (result_beat),
    .busy         (emit_busy)
  );

endmodule
